[hw/rtl/cbq_pkg.sv]
package cbq_pkg;

  localparam int STAGES_DEF    = 4;
  localparam int SETS_DEF      = 4;
  localparam int COEF_BITS_DEF = 24;

  localparam int SLOTS  = 5;
  localparam int DW     = 32;   // Q8.24 delay and data width
  localparam int ACC_W  = 36;   // room for x plus two shifted products
  localparam int STG_W  = 3;    // enough for up to eight stages
  localparam int STEP_W = 4;

  // step numbers inside one stage pass, set by the two-deep multiply pipe
  localparam logic [STEP_W-1:0] STEP_A1   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_A2   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_B0   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_B1   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_B2   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd8;

  // output mapping: floor((9*y + 2048*81920) / 81920), 81920 = 5 * 2^14
  localparam int                      OUT_W       = 38;
  localparam logic signed [OUT_W-1:0] OUT_OFFSET  = 38'sd167772160;
  localparam logic signed [OUT_W-1:0] OUT_LIMIT   = 38'sd335544320;
  localparam int                      OUT_SHIFT   = 14;
  localparam int                      Q_W         = 15;
  localparam logic [Q_W-1:0]          Q_MAX       = 15'd20475;
  localparam int                      RECIP_W     = 16;
  localparam logic [RECIP_W-1:0]      RECIP       = 16'd52429;
  localparam int                      RECIP_SHIFT = 18;
  localparam int                      CODE_W      = 12;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_COEF_WR = 2'd1,
    OP_NEXT    = 2'd2,
    OP_PREV    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    SLOT_B0 = 3'd0,
    SLOT_B1 = 3'd1,
    SLOT_B2 = 3'd2,
    SLOT_A1 = 3'd3,
    SLOT_A2 = 3'd4
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN,
    ST_QUANT,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic             take_sample;
    logic             coef_wr;
    logic             sel_next;
    logic             sel_prev;
    logic             issue;
    slot_t            slot;
    logic [STG_W-1:0] stage;
    logic             latch_w;
    logic             latch_y;
    logic [STG_W-1:0] y_stage;
    logic             calc_q;
    logic             out_load;
    logic             out_byp;
  } cmd_t;

  typedef struct packed {
    logic bypass;
  } status_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic hi_same;
    logic lo_same;
    hi_same = &v[ACC_W-1:DW-1];
    lo_same = ~|v[ACC_W-1:DW-1];
    if (hi_same || lo_same) begin
      sat32 = v[DW-1:0];
    end else begin
      sat32 = {v[ACC_W-1], {(DW-1){~v[ACC_W-1]}}};
    end
  endfunction

endpackage

[hw/rtl/cbq_ctrl.sv]
module cbq_ctrl #(
  parameter int STAGES = cbq_pkg::STAGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  output logic              out_valid,
  input  logic              out_ready,
  input  cbq_pkg::status_t  status,
  output cbq_pkg::cmd_t     cmd
);

  localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam logic [SW-1:0] STG_LAST = SW'(STAGES - 1);

  cbq_pkg::state_t state;
  cbq_pkg::state_t state_next;
  logic [cbq_pkg::STEP_W-1:0] cnt;
  logic [SW-1:0] stg;
  logic byp;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cbq_pkg::ST_IDLE: begin
        if (in_valid && op == cbq_pkg::OP_SAMPLE) begin
          state_next = status.bypass ? cbq_pkg::ST_HOLD : cbq_pkg::ST_RUN;
        end
      end
      cbq_pkg::ST_RUN: begin
        if (cnt == cbq_pkg::STEP_LAST && stg == STG_LAST) begin
          state_next = cbq_pkg::ST_FIN;
        end
      end
      cbq_pkg::ST_FIN: state_next = cbq_pkg::ST_QUANT;
      cbq_pkg::ST_QUANT: state_next = cbq_pkg::ST_HOLD;
      cbq_pkg::ST_HOLD: begin
        if (out_free) begin
          state_next = cbq_pkg::ST_IDLE;
        end
      end
      default: state_next = cbq_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      cbq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (op)
            cbq_pkg::OP_SAMPLE:  cmd.take_sample = 1'b1;
            cbq_pkg::OP_COEF_WR: cmd.coef_wr = 1'b1;
            cbq_pkg::OP_NEXT:    cmd.sel_next = 1'b1;
            cbq_pkg::OP_PREV:    cmd.sel_prev = 1'b1;
            default: ;
          endcase
        end
      end
      cbq_pkg::ST_RUN: begin
        cmd.stage = cbq_pkg::STG_W'(stg);
        case (cnt)
          cbq_pkg::STEP_A1: begin
            cmd.issue = 1'b1;
            cmd.slot  = cbq_pkg::SLOT_A1;
          end
          cbq_pkg::STEP_A2: begin
            cmd.issue = 1'b1;
            cmd.slot  = cbq_pkg::SLOT_A2;
          end
          cbq_pkg::STEP_B0: begin
            cmd.issue   = 1'b1;
            cmd.slot    = cbq_pkg::SLOT_B0;
            cmd.latch_w = 1'b1;
          end
          cbq_pkg::STEP_B1: begin
            cmd.issue = 1'b1;
            cmd.slot  = cbq_pkg::SLOT_B1;
          end
          cbq_pkg::STEP_B2: begin
            cmd.issue = 1'b1;
            cmd.slot  = cbq_pkg::SLOT_B2;
          end
          default: ;
        endcase
        // previous stage output lands while this stage starts
        if (cnt == cbq_pkg::STEP_A1 && stg != '0) begin
          cmd.latch_y = 1'b1;
          cmd.y_stage = cbq_pkg::STG_W'(stg - SW'(1));
        end
      end
      cbq_pkg::ST_FIN: begin
        cmd.latch_y = 1'b1;
        cmd.y_stage = cbq_pkg::STG_W'(STG_LAST);
      end
      cbq_pkg::ST_QUANT: cmd.calc_q = 1'b1;
      cbq_pkg::ST_HOLD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_byp  = byp;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cbq_pkg::ST_IDLE;
      cnt       <= '0;
      stg       <= '0;
      byp       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == cbq_pkg::ST_IDLE) begin
        cnt <= '0;
        stg <= '0;
        if (cmd.take_sample) begin
          byp <= status.bypass;
        end
      end else if (state == cbq_pkg::ST_RUN) begin
        if (cnt == cbq_pkg::STEP_LAST) begin
          cnt <= '0;
          if (stg != STG_LAST) begin
            stg <= stg + SW'(1);
          end
        end else begin
          cnt <= cnt + cbq_pkg::STEP_W'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("output register loaded while a result is pending");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    (state == cbq_pkg::ST_IDLE && in_valid && op == cbq_pkg::OP_SAMPLE && !status.bypass)
    |=> (state == cbq_pkg::ST_RUN && cnt == '0 && stg == '0))
    else $error("filter pass did not start at the first stage");

  a_latch_apart: assert property (@(posedge clk) disable iff (rst)
    !(cmd.latch_w && cmd.latch_y))
    else $error("w and y latched in the same cycle");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (state == cbq_pkg::ST_RUN && cnt == cbq_pkg::STEP_LAST && stg == STG_LAST)
    |=> state == cbq_pkg::ST_FIN)
    else $error("cascade did not finish after the last stage");

endmodule

[hw/rtl/cbq_datapath.sv]
module cbq_datapath #(
  parameter int STAGES    = cbq_pkg::STAGES_DEF,
  parameter int SETS      = cbq_pkg::SETS_DEF,
  parameter int COEF_BITS = cbq_pkg::COEF_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cbq_pkg::cmd_t       cmd,
  output cbq_pkg::status_t    status,
  input  logic [11:0]         sample,
  input  logic [1:0]          coef_set,
  input  logic [2:0]          coef_stage,
  input  logic [2:0]          coef_slot,
  input  logic signed [23:0]  coef_value,
  output logic [11:0]         out_code
);

  localparam int SW    = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int CW    = $clog2(SETS + 1);
  localparam int DEPTH = SETS * STAGES * cbq_pkg::SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int FRAC  = COEF_BITS - 2;
  localparam int PW    = COEF_BITS + cbq_pkg::DW;
  localparam int MW    = cbq_pkg::Q_W + cbq_pkg::RECIP_W;

  logic signed [COEF_BITS-1:0] coef_mem [DEPTH];
  logic signed [COEF_BITS-1:0] coef_q;

  logic signed [cbq_pkg::DW-1:0] d1 [STAGES];
  logic signed [cbq_pkg::DW-1:0] d2 [STAGES];
  logic signed [cbq_pkg::DW-1:0] d1_hold;
  logic signed [cbq_pkg::DW-1:0] w;
  logic signed [cbq_pkg::DW-1:0] x;
  logic signed [cbq_pkg::DW-1:0] opnd;
  logic signed [cbq_pkg::ACC_W-1:0] acc;
  logic signed [cbq_pkg::ACC_W-1:0] sh;
  logic signed [cbq_pkg::ACC_W-1:0] x_ext;
  logic signed [PW-1:0] prod;

  logic [CW-1:0] choice;
  logic [11:0]   sample_q;
  logic signed [11:0] ctr;

  logic          p1_valid;
  cbq_pkg::slot_t p1_slot;
  logic [SW-1:0] p1_stage;
  logic          p2_valid;
  cbq_pkg::slot_t p2_slot;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_ok;
  logic [SW-1:0] ys;

  logic signed [cbq_pkg::OUT_W-1:0] v;
  logic [cbq_pkg::Q_W-1:0] q;
  logic [MW-1:0] qm;

  assign status.bypass = (choice == '0);

  assign rd_addr = AW'((int'(choice) - 1) * (STAGES * cbq_pkg::SLOTS)
                       + int'(cmd.stage) * cbq_pkg::SLOTS + int'(cmd.slot));
  assign wr_addr = AW'((int'(coef_set) * STAGES + int'(coef_stage)) * cbq_pkg::SLOTS
                       + int'(coef_slot));
  assign wr_ok   = (int'(coef_set) < SETS) && (int'(coef_stage) < STAGES)
                   && (int'(coef_slot) < cbq_pkg::SLOTS);
  assign ys      = cmd.y_stage[SW-1:0];

  // coefficient store
  always_ff @(posedge clk) begin
    if (cmd.coef_wr && wr_ok) begin
      coef_mem[wr_addr] <= COEF_BITS'(coef_value);
    end
    if (cmd.issue) begin
      coef_q <= coef_mem[rd_addr];
    end
  end

  // filter selection
  always_ff @(posedge clk) begin
    if (rst) begin
      choice <= '0;
    end else if (cmd.sel_next) begin
      choice <= (choice == CW'(SETS)) ? '0 : choice + CW'(1);
    end else if (cmd.sel_prev) begin
      choice <= (choice == '0) ? CW'(SETS) : choice - CW'(1);
    end
  end

  // multiply pipe: coefficient read, product, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= cmd.issue;
      p2_valid <= p1_valid;
    end
  end

  always_comb begin
    case (p1_slot)
      cbq_pkg::SLOT_B0: opnd = w;
      cbq_pkg::SLOT_A1, cbq_pkg::SLOT_B1: opnd = d1[p1_stage];
      default: opnd = d2[p1_stage];
    endcase
  end

  assign sh    = cbq_pkg::ACC_W'(prod >>> FRAC);
  assign x_ext = cbq_pkg::ACC_W'(x);

  always_ff @(posedge clk) begin
    p1_slot  <= cmd.slot;
    p1_stage <= cmd.stage[SW-1:0];
    p2_slot  <= p1_slot;
    if (p1_valid) begin
      prod <= coef_q * opnd;
      if (p1_slot == cbq_pkg::SLOT_A1) begin
        d1_hold <= opnd;
      end
    end
    if (p2_valid) begin
      case (p2_slot)
        cbq_pkg::SLOT_A1: acc <= x_ext - sh;
        cbq_pkg::SLOT_A2: acc <= acc - sh;
        cbq_pkg::SLOT_B0: acc <= sh;
        cbq_pkg::SLOT_B1, cbq_pkg::SLOT_B2: acc <= acc + sh;
        default: acc <= acc;
      endcase
    end
    if (cmd.latch_w) begin
      w <= cbq_pkg::sat32(acc);
    end
  end

  // centered input in Q8.24: (sample - 2048) * 2^13
  assign ctr = {~sample[11], sample[10:0]};

  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      x        <= {{7{ctr[11]}}, ctr, 13'b0};
      sample_q <= sample;
    end else if (cmd.latch_y) begin
      x <= cbq_pkg::sat32(acc);
    end
  end

  // delay line
  always_ff @(posedge clk) begin
    if (rst || cmd.sel_next || cmd.sel_prev) begin
      for (int i = 0; i < STAGES; i++) begin
        d1[i] <= '0;
        d2[i] <= '0;
      end
    end else if (cmd.latch_y) begin
      d2[ys] <= d1_hold;
      d1[ys] <= w;
    end
  end

  // output mapping, divide by 5 through a reciprocal
  assign v  = (cbq_pkg::OUT_W'(x) <<< 3) + cbq_pkg::OUT_W'(x) + cbq_pkg::OUT_OFFSET;
  assign qm = q * cbq_pkg::RECIP;

  always_ff @(posedge clk) begin
    if (cmd.calc_q) begin
      if (v < 0) begin
        q <= '0;
      end else if (v >= cbq_pkg::OUT_LIMIT) begin
        q <= cbq_pkg::Q_MAX;
      end else begin
        q <= cbq_pkg::Q_W'(v >>> cbq_pkg::OUT_SHIFT);
      end
    end
    if (cmd.out_load) begin
      out_code <= cmd.out_byp ? sample_q : qm[cbq_pkg::RECIP_SHIFT +: cbq_pkg::CODE_W];
    end
  end

endmodule

[hw/rtl/cascaded_biquad_iir_filter_unit.sv]
// Cascaded direct-form-II biquad filter for 12-bit converter codes.
// Input channel (in_valid/in_ready) carries one request per item: op selects
// a sample, a coefficient write (coef_set, coef_stage, coef_slot, coef_value
// in Q2.22) or a step to the next or previous coefficient set.
// Output channel (out_valid/out_ready) returns out_code, one per sample.
// Coefficient writes and set steps finish in the cycle they are accepted and
// give no result; a set step also clears all delay values.
// With set 0 selected the sample is passed through the hold state into the
// output register, and the next request is taken in the cycle out_valid rises.
// Filtered samples run the stages one after another on a single multiplier,
// then the finish and quantize steps and the hold state, and the block takes
// the next request in the same cycle as out_valid rises.
// A request is taken while the previous result is still waiting; if the
// receiver stalls, a finished sample waits in the last step until the output
// register frees up, and in_ready stays low meanwhile.
// Reset selects set 0 and clears the delay values and out_valid; the
// coefficient store is undefined until written.
module cascaded_biquad_iir_filter_unit #(
  parameter int STAGES    = cbq_pkg::STAGES_DEF,
  parameter int SETS      = cbq_pkg::SETS_DEF,
  parameter int COEF_BITS = cbq_pkg::COEF_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [11:0]        sample,
  input  logic [1:0]         coef_set,
  input  logic [2:0]         coef_stage,
  input  logic [2:0]         coef_slot,
  input  logic signed [23:0] coef_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        out_code
);

  cbq_pkg::cmd_t    cmd;
  cbq_pkg::status_t status;

  cbq_ctrl #(
    .STAGES (STAGES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cbq_datapath #(
    .STAGES    (STAGES),
    .SETS      (SETS),
    .COEF_BITS (COEF_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .sample     (sample),
    .coef_set   (coef_set),
    .coef_stage (coef_stage),
    .coef_slot  (coef_slot),
    .coef_value (coef_value),
    .out_code   (out_code)
  );

endmodule
